// ===== sv/ssdv_pkg.sv =====
// ----------------------------------------------------------------------------
// ssdv_pkg: swept sine drum voice shared definitions
// Fixed-point constants, sequencer states and the sine and note tables. The
// tables are built at elaboration by constant functions.
// ----------------------------------------------------------------------------
package ssdv_pkg;

  // Table geometry
  localparam int SINE_TABLE_SIZE = 256;
  localparam int SINE_BITS       = $clog2(SINE_TABLE_SIZE);
  localparam int MAX_NOTE        = 151;
  localparam int NOTE_BITS       = $clog2(MAX_NOTE + 1);
  localparam int NOTE_OFFSET     = 12;
  localparam int TOP_NOTE        = 155;

  // Operation codes carried on tuser
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_NOTE_ON = 1'b1;

  // Fixed-point constants
  localparam logic [31:0] ONE_Q31     = 32'h8000_0000;
  localparam longint      ONE_Q30     = 64'sd1073741824;
  localparam logic [31:0] SWEEP_DECAY = 32'd2145980409;
  localparam logic [31:0] AMP_DECAY   = 32'd2147268900;
  // floor(x / 625) == (x * GROW_RECIP) >> 41 for any 31-bit x
  localparam logic [31:0] GROW_RECIP  = 32'd3518437209;

  // Shared multiplier geometry
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_FETCH  = 11'b000_0000_0010,
    ST_INTERP = 11'b000_0000_0100,
    ST_AMPSQ  = 11'b000_0000_1000,
    ST_SAMP   = 11'b000_0001_0000,
    ST_SWEEP  = 11'b000_0010_0000,
    ST_AMPD   = 11'b000_0100_0000,
    ST_GROW   = 11'b000_1000_0000,
    ST_RECIP  = 11'b001_0000_0000,
    ST_STEP   = 11'b010_0000_0000,
    ST_EMIT   = 11'b100_0000_0000
  } state_t;

  // Sequencer to datapath control
  typedef struct packed {
    state_t state;
    logic   in_ready;
    logic   mul_en;
  } ssdv_ctrl_t;

  typedef logic [SINE_TABLE_SIZE:0][31:0] sine_tab_t;
  typedef logic [MAX_NOTE:0][32:0]        note_tab_t;

  // Odd polynomial coefficients for a quarter sine, Q30
  function automatic longint poly_coef(input int k);
    longint c;
    case (k)
      0:       c = 64'sd1686629713;
      1:       c = -64'sd693598668;
      2:       c = 64'sd85569305;
      3:       c = -64'sd5026995;
      4:       c = 64'sd172272;
      5:       c = -64'sd3864;
      default: c = 64'sd61;
    endcase
    return c;
  endfunction

  // sin(pi/2 * t), t and result in Q30
  function automatic longint quarter_sine(input longint t);
    longint t2;
    longint acc;
    t2  = t * t / ONE_Q30;
    acc = poly_coef(6);
    for (int k = 5; k >= 0; k--) begin
      acc = poly_coef(k) + acc * t2 / ONE_Q30;
    end
    acc = acc * t / ONE_Q30;
    if (acc < 0) acc = 0;
    if (acc > ONE_Q30) acc = ONE_Q30;
    return acc;
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint    u;
    longint    quad;
    longint    rem;
    longint    t;
    longint    v;
    for (int i = 0; i <= SINE_TABLE_SIZE; i++) begin
      u    = longint'(i) * 4;
      quad = u / SINE_TABLE_SIZE;
      rem  = u - quad * SINE_TABLE_SIZE;
      t    = (rem <<< 30) / SINE_TABLE_SIZE;
      case (quad)
        0:       v = quarter_sine(t);
        1:       v = quarter_sine(ONE_Q30 - t);
        2:       v = -quarter_sine(t);
        3:       v = -quarter_sine(ONE_Q30 - t);
        default: v = 0;
      endcase
      tab[i] = v[31:0];
    end
    return tab;
  endfunction

  // Phase steps of the top octave, Q1.32 at 48 kHz
  function automatic longint top_octave(input longint k);
    longint s;
    case (k)
      0:       s = 64'sd2996461992;
      1:       s = 64'sd3174640894;
      2:       s = 64'sd3363414866;
      3:       s = 64'sd3563413921;
      4:       s = 64'sd3775305539;
      5:       s = 64'sd3999796889;
      6:       s = 64'sd4237637188;
      7:       s = 64'sd4489620208;
      8:       s = 64'sd4756586918;
      9:       s = 64'sd5039428295;
      10:      s = 64'sd5339088295;
      default: s = 64'sd5656567006;
    endcase
    return s;
  endfunction

  // Octave image of the top octave, shifted right rounding half up
  function automatic longint note_step(input int n);
    longint back;
    longint down;
    longint half;
    back = longint'(TOP_NOTE - n);
    down = back / 12;
    half = (longint'(1) <<< down) >>> 1;
    return (top_octave(11 - back % 12) + half) >>> down;
  endfunction

  function automatic note_tab_t build_note_tab();
    note_tab_t tab;
    for (int n = 0; n <= MAX_NOTE; n++) begin
      tab[n] = 33'(note_step(n));
    end
    return tab;
  endfunction

  localparam sine_tab_t   SINE_TAB = build_sine_tab();
  localparam note_tab_t   NOTE_TAB = build_note_tab();
  localparam logic [32:0] STEP_CAP = 33'(note_step(MAX_NOTE));

endpackage

// ===== sv/swept_sine_drum_voice.sv =====
// ----------------------------------------------------------------------------
// swept_sine_drum_voice: sine drum voice with decaying pitch sweep
// Phase accumulator into an interpolated sine table, scaled by the squared
// amplitude level; amplitude and sweep decay after every sample and the sweep
// raises the phase step.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | handshake
//  in_     | in  | tuser: operation, tdata: note    | in_tvalid / in_tready
//  out_    | out | tdata: sample (Q1.31, signed)    | out_tvalid / out_tready
//
//  A note on gives no result. A sample tick holds in_tready low from
//  acceptance until its sample is handed over: seven passes through the
//  one shared 34x34 multiplier plus fetch, step update and output
//  hand-over; a stall on out_tready holds the last step only.
//  The output register lets a finished sample wait while the next request is
//  taken. Reset is synchronous: phase and step to zero, both levels to 1.0.
// ----------------------------------------------------------------------------
module swept_sine_drum_voice (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] note
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] sample
);

  localparam int SB = ssdv_pkg::SINE_BITS;
  localparam int MW = ssdv_pkg::MUL_W;
  localparam int PW = ssdv_pkg::PROD_W;

  ssdv_pkg::ssdv_ctrl_t ctrl;

  logic              tick_start;
  logic              note_start;
  logic              out_free;

  // Voice state
  logic [31:0]       phase_r,  phase_nxt;
  logic [32:0]       step_r,   step_nxt;
  logic [31:0]       sweep_r,  sweep_nxt;
  logic [31:0]       amp_r,    amp_nxt;

  // Working registers of a tick
  logic signed [31:0] a_r,     a_nxt;
  logic signed [32:0] diff_r,  diff_nxt;
  logic signed [31:0] s_r,     s_nxt;
  logic [31:0]        y_r,     y_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_data_r,  out_data_nxt;

  // Table lookup
  logic [SB-1:0]      tab_idx;
  logic [SB:0]        tab_idx_nx;
  logic [31:0]        frac;
  logic signed [31:0] tab_a;
  logic signed [31:0] tab_b;

  // Note lookup
  logic [7:0]         note_m;
  logic [7:0]         note_c;

  // Multiplier
  logic signed [MW-1:0] op_a;
  logic signed [MW-1:0] op_b;
  logic signed [PW-1:0] prod;

  // Product views
  logic               interp_corr;
  logic signed [31:0] interp_q;
  logic [31:0]        v2;
  logic signed [37:0] y_full;
  logic               y_corr;
  logic signed [37:0] y_t;
  logic [30:0]        grow_x;
  logic [21:0]        grow_inc;
  logic [33:0]        step_sum;

  assign in_tready  = ctrl.in_ready;
  assign tick_start = in_tvalid && ctrl.in_ready && (in_tuser == ssdv_pkg::OP_TICK);
  assign note_start = in_tvalid && ctrl.in_ready && (in_tuser == ssdv_pkg::OP_NOTE_ON);
  assign out_free   = !out_valid_r || out_tready;

  ssdv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_start (tick_start),
    .out_free   (out_free),
    .ctrl       (ctrl)
  );

  ssdv_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Split the phase into table index and interpolation fraction
  assign tab_idx    = phase_r[31 -: SB];
  assign tab_idx_nx = {1'b0, tab_idx} + (SB+1)'(1);
  assign frac       = {phase_r[31-SB:0], {SB{1'b0}}};
  assign tab_a      = $signed(ssdv_pkg::SINE_TAB[{1'b0, tab_idx}]);
  assign tab_b      = $signed(ssdv_pkg::SINE_TAB[tab_idx_nx]);

  // Drop the note by an octave, clamp at both ends
  assign note_m = (in_tdata < 8'(ssdv_pkg::NOTE_OFFSET)) ? 8'd0
                : in_tdata - 8'(ssdv_pkg::NOTE_OFFSET);
  assign note_c = (note_m > 8'(ssdv_pkg::MAX_NOTE)) ? 8'(ssdv_pkg::MAX_NOTE) : note_m;

  // Truncate products toward zero and pick out the fixed-point fields
  assign interp_corr = prod[PW-1] && (|prod[31:0]);
  assign interp_q    = prod[63:32];
  assign v2          = prod[62:31];
  assign y_full      = prod[67:30];
  assign y_corr      = prod[PW-1] && (|prod[29:0]);
  assign y_t         = y_full + 38'(y_corr);
  assign grow_x      = prod[56:26];
  assign grow_inc    = prod[62:41];
  assign step_sum    = {1'b0, step_r} + 34'(grow_inc);

  // Select the operands of the pass being issued
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctrl.state)
      ssdv_pkg::ST_INTERP: begin
        op_a = MW'(diff_r);
        op_b = {2'b00, frac};
      end
      ssdv_pkg::ST_AMPSQ: begin
        op_a = {2'b00, amp_r};
        op_b = {2'b00, amp_r};
      end
      ssdv_pkg::ST_SAMP: begin
        op_a = MW'(s_r);
        op_b = {2'b00, v2};
      end
      ssdv_pkg::ST_SWEEP: begin
        op_a = {2'b00, sweep_r};
        op_b = {2'b00, ssdv_pkg::SWEEP_DECAY};
      end
      ssdv_pkg::ST_AMPD: begin
        op_a = {2'b00, amp_r};
        op_b = {2'b00, ssdv_pkg::AMP_DECAY};
      end
      ssdv_pkg::ST_GROW: begin
        op_a = {1'b0, step_r};
        op_b = {10'd0, sweep_r[31:8]};
      end
      ssdv_pkg::ST_RECIP: begin
        op_a = {3'b000, grow_x};
        op_b = {2'b00, ssdv_pkg::GROW_RECIP};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Update state and working registers for each pass
  always_comb begin
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    sweep_nxt     = sweep_r;
    amp_nxt       = amp_r;
    a_nxt         = a_r;
    diff_nxt      = diff_r;
    s_nxt         = s_r;
    y_nxt         = y_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (ctrl.state)
      ssdv_pkg::ST_IDLE: begin
        if (note_start) begin
          step_nxt  = ssdv_pkg::NOTE_TAB[note_c[ssdv_pkg::NOTE_BITS-1:0]];
          sweep_nxt = ssdv_pkg::ONE_Q31;
          amp_nxt   = ssdv_pkg::ONE_Q31;
        end
      end
      ssdv_pkg::ST_FETCH: begin
        a_nxt    = tab_a;
        diff_nxt = 33'(tab_b) - 33'(tab_a);
      end
      ssdv_pkg::ST_AMPSQ: begin
        s_nxt = a_r + interp_q + 32'(interp_corr);
      end
      ssdv_pkg::ST_SWEEP: begin
        if (y_t > 38'sd2147483647) begin
          y_nxt = 32'h7FFF_FFFF;
        end else if (y_t < -38'sd2147483648) begin
          y_nxt = 32'h8000_0000;
        end else begin
          y_nxt = y_t[31:0];
        end
      end
      ssdv_pkg::ST_AMPD: begin
        sweep_nxt = prod[62:31];
      end
      ssdv_pkg::ST_GROW: begin
        amp_nxt = prod[62:31];
      end
      ssdv_pkg::ST_STEP: begin
        step_nxt = (step_sum > {1'b0, ssdv_pkg::STEP_CAP}) ? ssdv_pkg::STEP_CAP
                 : step_sum[32:0];
      end
      ssdv_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = y_r;
          phase_nxt     = phase_r + step_r[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Voice state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      step_r      <= '0;
      sweep_r     <= ssdv_pkg::ONE_Q31;
      amp_r       <= ssdv_pkg::ONE_Q31;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      sweep_r     <= sweep_nxt;
      amp_r       <= amp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    diff_r     <= diff_nxt;
    s_r        <= s_nxt;
    y_r        <= y_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_amp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    amp_r <= ssdv_pkg::ONE_Q31)
    else $error("amplitude level above 1.0");

  a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= ssdv_pkg::STEP_CAP)
    else $error("phase step above the top-note cap");

  a_note_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (note_start && !out_valid_r) |=> !out_tvalid)
    else $error("note on produced a sample");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tick_start |=> !in_tready)
    else $error("ready while a tick is in progress");
`endif

endmodule

// ===== sv/ssdv_mul.sv =====
// ----------------------------------------------------------------------------
// ssdv_mul: shared signed multiplier
// One signed multiply with a registered product, reused for every product of
// a sample tick.
// ----------------------------------------------------------------------------
module ssdv_mul (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic signed [ssdv_pkg::MUL_W-1:0]        op_a,
  input  logic signed [ssdv_pkg::MUL_W-1:0]        op_b,
  output logic signed [ssdv_pkg::PROD_W-1:0]       prod
);

  logic signed [ssdv_pkg::PROD_W-1:0] prod_r;
  logic signed [ssdv_pkg::PROD_W-1:0] prod_nxt;

  // Form the full-width product
  assign prod_nxt = ssdv_pkg::PROD_W'(op_a) * ssdv_pkg::PROD_W'(op_b);

  // Hold the product until the next issue
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

// ===== sv/ssdv_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssdv_ctrl: tick sequencer
// Steps a sample tick through the multiplier passes and waits for the output
// register before finishing.
// ----------------------------------------------------------------------------
module ssdv_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick_start,
  input  logic                 out_free,
  output ssdv_pkg::ssdv_ctrl_t ctrl
);

  ssdv_pkg::state_t state_r;
  ssdv_pkg::state_t state_nxt;

  // Advance one pass per cycle, hold at the end while the output is full
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssdv_pkg::ST_IDLE:   if (tick_start) state_nxt = ssdv_pkg::ST_FETCH;
      ssdv_pkg::ST_FETCH:  state_nxt = ssdv_pkg::ST_INTERP;
      ssdv_pkg::ST_INTERP: state_nxt = ssdv_pkg::ST_AMPSQ;
      ssdv_pkg::ST_AMPSQ:  state_nxt = ssdv_pkg::ST_SAMP;
      ssdv_pkg::ST_SAMP:   state_nxt = ssdv_pkg::ST_SWEEP;
      ssdv_pkg::ST_SWEEP:  state_nxt = ssdv_pkg::ST_AMPD;
      ssdv_pkg::ST_AMPD:   state_nxt = ssdv_pkg::ST_GROW;
      ssdv_pkg::ST_GROW:   state_nxt = ssdv_pkg::ST_RECIP;
      ssdv_pkg::ST_RECIP:  state_nxt = ssdv_pkg::ST_STEP;
      ssdv_pkg::ST_STEP:   state_nxt = ssdv_pkg::ST_EMIT;
      ssdv_pkg::ST_EMIT:   if (out_free) state_nxt = ssdv_pkg::ST_IDLE;
      default:             state_nxt = ssdv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssdv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Drive the datapath controls
  always_comb begin
    ctrl.state    = state_r;
    ctrl.in_ready = (state_r == ssdv_pkg::ST_IDLE);
    ctrl.mul_en   = (state_r == ssdv_pkg::ST_INTERP) || (state_r == ssdv_pkg::ST_AMPSQ) ||
                    (state_r == ssdv_pkg::ST_SAMP)   || (state_r == ssdv_pkg::ST_SWEEP) ||
                    (state_r == ssdv_pkg::ST_AMPD)   || (state_r == ssdv_pkg::ST_GROW)  ||
                    (state_r == ssdv_pkg::ST_RECIP);
  end

endmodule
